// ----- hdl/mi3_pkg.sv -----
// Shared widths, result types and the saturator for the 3x3 matrix inverse.
// Used by the channel interfaces and by matrix_inverse_3x3_unit; depends on nothing.
package mi3_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int SPLIT_W   = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int COF_W     = PROD_W + 1;
    localparam int DET_W     = COF_W + DATA_W;
    localparam int DM_W      = DET_W;
    localparam int REM_W     = DM_W + 1;
    localparam int QUO_W     = DATA_W + 1;
    localparam int NSH       = 2 * FRAC_BITS + 1;
    localparam int NUM_W     = ((COF_W + NSH > REM_W) ? COF_W + NSH : REM_W) + 1;
    localparam int PRE_STG   = 5;
    localparam int PIPE_STG  = PRE_STG + QUO_W + 1;
    localparam int N_ENT     = 9;

    localparam logic [DM_W:0]     RND_HALF = (DM_W + 1)'(1) << (2 * FRAC_BITS - 1);
    localparam logic [QUO_W-1:0]  POS_LIM  = QUO_W'(33'h0_7FFF_FFFF);
    localparam logic [QUO_W-1:0]  NEG_LIM  = QUO_W'(33'h0_8000_0000);
    localparam logic [DATA_W-1:0] SAT_POS  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_NEG  = 32'h8000_0000;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] x;
        logic             ovf;
        logic             neg;
    } t_ent;

    typedef struct packed {
        t_ent [N_ENT-1:0] ent;
        logic [REM_W-1:0] dp;
        logic             sing;
        logic [DATA_W-1:0] detv;
    } t_div;

    typedef struct packed {
        logic [N_ENT-1:0][DATA_W-1:0] inv;
        logic [DATA_W-1:0]            detv;
        logic                         sing;
    } t_res;

    function automatic logic [DATA_W-1:0] f_sat(input logic neg, input logic hi_nz,
                                                input logic [QUO_W-1:0] q);
        logic [DATA_W-1:0] res;
        if (!neg) begin
            res = (hi_nz || q > POS_LIM) ? SAT_POS : q[DATA_W-1:0];
        end else begin
            res = (hi_nz || q > NEG_LIM) ? SAT_NEG : (~q[DATA_W-1:0]) + DATA_W'(1);
        end
        return res;
    endfunction

endpackage

// ----- hdl/mi3_in_if.sv -----
// Input channel of the 3x3 matrix inverse: valid, ready and the nine matrix entries.
// Depends on mi3_pkg for the entry width.
interface mi3_in_if;
    logic valid;
    logic ready;
    logic signed [mi3_pkg::DATA_W-1:0] a_00, a_01, a_02;
    logic signed [mi3_pkg::DATA_W-1:0] a_10, a_11, a_12;
    logic signed [mi3_pkg::DATA_W-1:0] a_20, a_21, a_22;

    modport source(output valid, a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22,
                   input ready);
    modport sink(input valid, a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22,
                 output ready);
endinterface

// ----- hdl/mi3_out_if.sv -----
// Result channel of the 3x3 matrix inverse: valid, ready, inverse, determinant, flag.
// Depends on mi3_pkg for the entry width.
interface mi3_out_if;
    logic valid;
    logic ready;
    logic signed [mi3_pkg::DATA_W-1:0] inv_00, inv_01, inv_02;
    logic signed [mi3_pkg::DATA_W-1:0] inv_10, inv_11, inv_12;
    logic signed [mi3_pkg::DATA_W-1:0] inv_20, inv_21, inv_22;
    logic signed [mi3_pkg::DATA_W-1:0] det_value;
    logic singular;

    modport source(output valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12,
                   inv_20, inv_21, inv_22, det_value, singular, input ready);
    modport sink(input valid, inv_00, inv_01, inv_02, inv_10, inv_11, inv_12,
                 inv_20, inv_21, inv_22, det_value, singular, output ready);
endinterface

// ----- hdl/matrix_inverse_3x3_unit.sv -----
// Pipelined 3x3 matrix inverse by the adjugate in signed Q16.16.
// Depends on mi3_pkg, mi3_in_if and mi3_out_if.
//
// One matrix is taken per transfer on i_in and one result is given per transfer
// on o_out: the nine rounded and saturated inverse entries, the rounded
// determinant and the singular flag. A zero determinant gives zero entries.
// Throughput is one matrix per cycle while the receiver does not stall. The path
// from the input transfer to o_out.valid runs through five stages of products,
// cofactors and determinant, one setup stage and 33 restoring division stages,
// one quotient bit each, run in nine parallel lanes, plus the output register.
// A synchronous active-low reset empties the pipeline; payload is not cleared.
// While the receiver stalls, the pipeline keeps moving until one further
// result fills a skid register behind the output register; i_in.ready then
// drops and the whole pipeline holds, losing nothing.
module matrix_inverse_3x3_unit (
    input logic        i_clk,
    input logic        i_rst_n,
    mi3_in_if.sink     i_in,
    mi3_out_if.source  o_out
);

    localparam int DW = mi3_pkg::DATA_W;
    localparam int PW = mi3_pkg::PROD_W;
    localparam int CW = mi3_pkg::COF_W;
    localparam int TW = mi3_pkg::DET_W;
    localparam int MW = mi3_pkg::DM_W;
    localparam int RW = mi3_pkg::REM_W;
    localparam int QW = mi3_pkg::QUO_W;
    localparam int NW = mi3_pkg::NUM_W;
    localparam int SW = mi3_pkg::SPLIT_W;
    localparam int PS = mi3_pkg::PIPE_STG;

    logic                  w_en;
    logic [PS-1:0]         r_vld;
    logic signed [DW-1:0]  w_a   [3][3];
    logic signed [PW-1:0]  w_pa  [3][3];
    logic signed [PW-1:0]  w_pb  [3][3];
    logic signed [PW-1:0]  r_pa  [3][3];
    logic signed [PW-1:0]  r_pb  [3][3];
    logic signed [DW-1:0]  r_a0  [3];
    logic signed [CW-1:0]  r_cof1 [3][3];
    logic signed [DW-1:0]  r_a1  [3];
    logic signed [CW:0]    w_ph  [3];
    logic signed [CW:0]    w_pl  [3];
    logic signed [CW:0]    r_ph  [3];
    logic signed [CW:0]    r_pl  [3];
    logic signed [CW-1:0]  r_cof2 [3][3];
    logic signed [TW-1:0]  r_det;
    logic signed [CW-1:0]  r_cof3 [3][3];
    logic [MW-1:0]         r_dm;
    logic [CW-1:0]         r_cm  [3][3];
    logic                  r_neg [3][3];
    logic                  r_dneg;
    logic                  r_sing;
    logic [NW-1:0]         w_num [3][3];
    logic [RW-1:0]         w_dp;
    logic [MW:0]           w_dq;
    mi3_pkg::t_div         n_dv0;
    mi3_pkg::t_div         r_dv  [0:QW];
    mi3_pkg::t_div         n_dv  [1:QW];
    mi3_pkg::t_res         w_fmt;
    mi3_pkg::t_res         r_res;
    mi3_pkg::t_res         r_skid;
    logic                  r_ov;
    logic                  r_sv;
    logic                  w_arr;
    logic                  w_take;

    assign w_en       = !r_sv;
    assign i_in.ready = w_en;

    assign w_a[0][0] = i_in.a_00;
    assign w_a[0][1] = i_in.a_01;
    assign w_a[0][2] = i_in.a_02;
    assign w_a[1][0] = i_in.a_10;
    assign w_a[1][1] = i_in.a_11;
    assign w_a[1][2] = i_in.a_12;
    assign w_a[2][0] = i_in.a_20;
    assign w_a[2][1] = i_in.a_21;
    assign w_a[2][2] = i_in.a_22;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PS-2:0], i_in.valid};
        end
    end

    for (genvar gr = 0; gr < 3; gr++) begin : g_row
        for (genvar gc = 0; gc < 3; gc++) begin : g_col
            localparam int R1 = (gr + 1) % 3;
            localparam int R2 = (gr + 2) % 3;
            localparam int C1 = (gc + 1) % 3;
            localparam int C2 = (gc + 2) % 3;

            assign w_pa[gr][gc] = w_a[R1][C1] * w_a[R2][C2];
            assign w_pb[gr][gc] = w_a[R1][C2] * w_a[R2][C1];
            assign w_num[gr][gc] = (NW'(r_cm[gc][gr]) << mi3_pkg::NSH) + NW'(r_dm);

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_pa[gr][gc]   <= w_pa[gr][gc];
                    r_pb[gr][gc]   <= w_pb[gr][gc];
                    r_cof1[gr][gc] <= CW'(r_pa[gr][gc]) - CW'(r_pb[gr][gc]);
                    r_cof2[gr][gc] <= r_cof1[gr][gc];
                    r_cof3[gr][gc] <= r_cof2[gr][gc];
                    r_cm[gr][gc]   <= r_cof3[gr][gc][CW-1] ? CW'(-r_cof3[gr][gc])
                                                           : CW'(r_cof3[gr][gc]);
                    r_neg[gr][gc]  <= r_cof3[gr][gc][CW-1] ^ r_det[TW-1];
                end
            end
        end

        assign w_ph[gr] = $signed(r_cof1[0][gr][CW-1:SW]) * r_a1[gr];
        assign w_pl[gr] = $signed({1'b0, r_cof1[0][gr][SW-1:0]}) * r_a1[gr];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_a0[gr] <= w_a[0][gr];
                r_a1[gr] <= r_a0[gr];
                r_ph[gr] <= w_ph[gr];
                r_pl[gr] <= w_pl[gr];
            end
        end
    end

    assign w_dp = RW'(r_dm) << 1;
    assign w_dq = ((MW + 1)'(r_dm) + mi3_pkg::RND_HALF) >> (2 * mi3_pkg::FRAC_BITS);

    always_comb begin
        n_dv0.dp   = w_dp;
        n_dv0.sing = r_sing;
        n_dv0.detv = mi3_pkg::f_sat(r_dneg, |w_dq[MW:QW], w_dq[QW-1:0]);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                n_dv0.ent[i*3+j].ovf = (NW'(w_num[i][j] >> QW) >= NW'(w_dp));
                n_dv0.ent[i*3+j].rem = RW'(w_num[i][j] >> QW);
                n_dv0.ent[i*3+j].x   = w_num[i][j][QW-1:0];
                n_dv0.ent[i*3+j].neg = r_neg[j][i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_det  <= (TW'(r_ph[0]) <<< SW) + TW'(r_pl[0])
                    + (TW'(r_ph[1]) <<< SW) + TW'(r_pl[1])
                    + (TW'(r_ph[2]) <<< SW) + TW'(r_pl[2]);
            r_dm   <= r_det[TW-1] ? MW'(-r_det) : MW'(r_det);
            r_dneg <= r_det[TW-1];
            r_sing <= (r_det == '0);
            r_dv[0] <= n_dv0;
        end
    end

    for (genvar gk = 0; gk < QW; gk++) begin : g_div
        always_comb begin
            logic [RW:0] t;
            logic        ge;
            n_dv[gk+1] = r_dv[gk];
            for (int e = 0; e < mi3_pkg::N_ENT; e++) begin
                t  = {r_dv[gk].ent[e].rem, r_dv[gk].ent[e].x[QW-1]};
                ge = (t >= (RW + 1)'(r_dv[gk].dp));
                n_dv[gk+1].ent[e].rem = ge ? RW'(t - (RW + 1)'(r_dv[gk].dp)) : RW'(t);
                n_dv[gk+1].ent[e].x   = {r_dv[gk].ent[e].x[QW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv[gk+1] <= n_dv[gk+1];
            end
        end
    end

    always_comb begin
        w_fmt.detv = r_dv[QW].detv;
        w_fmt.sing = r_dv[QW].sing;
        for (int e = 0; e < mi3_pkg::N_ENT; e++) begin
            w_fmt.inv[e] = r_dv[QW].sing ? '0
                         : mi3_pkg::f_sat(r_dv[QW].ent[e].neg, r_dv[QW].ent[e].ovf,
                                          r_dv[QW].ent[e].x);
        end
    end

    assign w_arr  = w_en && r_vld[PS-1];
    assign w_take = r_ov && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (w_take) begin
                r_sv <= 1'b0;
            end
        end else if (w_arr) begin
            if (r_ov && !w_take) begin
                r_sv <= 1'b1;
            end
            r_ov <= 1'b1;
        end else if (w_take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (w_take) begin
                r_res <= r_skid;
            end
        end else if (w_arr) begin
            if (r_ov && !w_take) begin
                r_skid <= w_fmt;
            end else begin
                r_res <= w_fmt;
            end
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.inv_00    = r_res.inv[0];
    assign o_out.inv_01    = r_res.inv[1];
    assign o_out.inv_02    = r_res.inv[2];
    assign o_out.inv_10    = r_res.inv[3];
    assign o_out.inv_11    = r_res.inv[4];
    assign o_out.inv_12    = r_res.inv[5];
    assign o_out.inv_20    = r_res.inv[6];
    assign o_out.inv_21    = r_res.inv[7];
    assign o_out.inv_22    = r_res.inv[8];
    assign o_out.det_value = r_res.detv;
    assign o_out.singular  = r_res.sing;

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.singular |-> o_out.det_value == '0 && o_out.inv_00 == '0
            && o_out.inv_11 == '0 && o_out.inv_22 == '0 && o_out.inv_12 == '0)
        else $error("singular result with nonzero fields");

    a_skid_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid register full while output register empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sv) |-> $past(r_ov && !o_out.ready && r_vld[PS-1]))
        else $error("skid register filled without a stalled transfer");

endmodule
